@@ rtl/core/tsu_pkg.sv @@
// ----------------------------------------------------------------------------
// tsu_pkg: shared types and constants for timestamp unwrap / clock recovery
// Payload structs, register indexes, reset values, remainder unit interface.
// ----------------------------------------------------------------------------
package tsu_pkg;

	localparam int STAMP_BITS = 44;
	localparam int TIME_BITS  = 64;
	localparam int IVL_BITS   = 32;
	localparam int DELAY_BITS = 44;
	localparam int CNT_BITS   = $clog2(TIME_BITS + 1);

	localparam logic [IVL_BITS-1:0]   RESET_INTERVAL = IVL_BITS'(27000000);
	localparam logic [DELAY_BITS-1:0] RESET_DELAY    = DELAY_BITS'(1620000000);
	localparam logic [TIME_BITS-1:0]  RESET_CLOCK    = TIME_BITS'(64'd4294967295);

	// configuration register indexes
	localparam logic CFG_REF_INTERVAL_MAX = 1'b0;
	localparam logic CFG_DATE_DELAY_MAX   = 1'b1;

	typedef struct packed {
		logic                  is_reference;
		logic [STAMP_BITS-1:0] orig_stamp;
		logic [STAMP_BITS-1:0] wrap_period;
	} in_item_t;

	typedef struct packed {
		logic                 ref_valid;
		logic [TIME_BITS-1:0] ref_time;
		logic                 ref_discontinuity;
		logic                 date_valid;
		logic [TIME_BITS-1:0] program_date;
	} out_item_t;

	// command to the shared remainder unit
	typedef struct packed {
		logic                  start;
		logic [TIME_BITS-1:0]  dividend;  // left aligned, MSB first
		logic [CNT_BITS-1:0]   nbits;
		logic [STAMP_BITS-1:0] divisor;
	} rem_cmd_t;

	typedef struct packed {
		logic                  done;
		logic [STAMP_BITS-1:0] rem;
	} rem_stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOD_STAMP,
		ST_MOD_CLK,
		ST_REF,
		ST_SUM,
		ST_MAG,
		ST_DATE,
		ST_DONE
	} state_t;

endpackage

@@ rtl/core/tsu_rem.sv @@
// ----------------------------------------------------------------------------
// tsu_rem: bit-serial remainder unit
// Restoring remainder, one dividend bit per cycle, MSB first; done pulses
// in the cycle after the last bit with the remainder held until the next start.
// ----------------------------------------------------------------------------
module tsu_rem (
	input  logic              clk,
	input  logic              arst_n,
	input  tsu_pkg::rem_cmd_t cmd,
	output tsu_pkg::rem_stat_t stat
);
	import tsu_pkg::*;

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic [TIME_BITS-1:0]  dvd_q;
	logic [STAMP_BITS-1:0] dvs_q;
	logic [STAMP_BITS-1:0] rem_q;

	logic [STAMP_BITS:0]   trial;
	logic [STAMP_BITS:0]   diff;
	logic [STAMP_BITS-1:0] rem_nxt;

	always_comb begin
		trial = {rem_q, dvd_q[TIME_BITS-1]};
		diff  = trial - {1'b0, dvs_q};
		if (trial >= {1'b0, dvs_q}) begin
			rem_nxt = diff[STAMP_BITS-1:0];
		end else begin
			rem_nxt = trial[STAMP_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (cmd.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= cmd.nbits;
		end else if (busy_q) begin
			cnt_q  <= cnt_q - CNT_BITS'(1);
			busy_q <= (cnt_q != CNT_BITS'(1));
			done_q <= (cnt_q == CNT_BITS'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			dvd_q <= cmd.dividend;
			dvs_q <= cmd.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[TIME_BITS-2:0], 1'b0};
			rem_q <= rem_nxt;
		end
	end

	assign stat.done = done_q;
	assign stat.rem  = rem_q;

endmodule

@@ rtl/core/timestamp_unwrap_clock_recovery.sv @@
// ----------------------------------------------------------------------------
// timestamp_unwrap_clock_recovery: wrapped stream timestamps to program dates
// Tracks an unwrapped reference clock and converts each stamp to a date.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one timestamp per transfer (is_reference, orig_stamp, wrap_period).
//   out_* : one result per input transfer, in order.
//   cfg_* : register writes (index 0 ref_interval_max, 1 date_delay_max),
//           always ready; write only while the block is idle.
// Datapath: both remainders (stamp and reference clock modulo the wrap period)
//   run one bit per cycle through a single shared remainder unit; one item
//   is in work at a time and in_ready is high only between items.
// Stall: the result sits in an output register; the next item is accepted
//   meanwhile and finishes up to the output stage, where it waits.
// Reset: registers to their defaults, reference clock and highest date to
//   2^32-1, offset to zero, no result pending.
// ----------------------------------------------------------------------------
module timestamp_unwrap_clock_recovery (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  tsu_pkg::in_item_t            in_item,
	output logic                         out_valid,
	input  logic                         out_ready,
	output tsu_pkg::out_item_t           out_item,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic                         cfg_index,
	input  logic [tsu_pkg::TIME_BITS-1:0] cfg_data
);
	import tsu_pkg::*;

	localparam int SW = STAMP_BITS;

	state_t state_q, state_nxt;

	// registers and state
	logic [IVL_BITS-1:0]   ivl_max_q;
	logic [DELAY_BITS-1:0] delay_max_q;
	logic [TIME_BITS-1:0]  ref_clock_q;
	logic [TIME_BITS-1:0]  prog_offset_q;
	logic [TIME_BITS-1:0]  highest_q;

	// per-item working registers
	logic                  is_ref_q;
	logic [SW-1:0]         stamp_q;
	logic [SW-1:0]         period_q;
	logic [SW-1:0]         a_q;
	logic [SW-1:0]         b_q;
	logic [SW-1:0]         dist_q;
	logic                  disc_q;
	logic [TIME_BITS-1:0]  ref_time_q;
	logic [SW-1:0]         t_q;
	logic                  neg_q;
	logic [SW-1:0]         mag_q;
	logic                  ok_q;
	logic [TIME_BITS-1:0]  date_q;

	logic                  out_valid_q;
	out_item_t             out_q;

	rem_cmd_t              rem_cmd;
	rem_stat_t             rem_stat;

	logic                  in_xfer;
	logic                  out_load;
	logic [SW-1:0]         period_in;
	logic [SW-1:0]         half;
	logic [SW:0]           fwd_sum;
	logic [SW:0]           fwd_sub;
	logic [SW-1:0]         fwd;
	logic                  over;
	logic [SW:0]           t_sum;
	logic [SW:0]           t_sub;
	logic [SW-1:0]         t_nxt;
	logic                  neg_nxt;
	logic [SW-1:0]         mag_nxt;
	logic [TIME_BITS-1:0]  mag64;

	tsu_rem u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (rem_cmd),
		.stat   (rem_stat)
	);

	assign in_xfer   = in_valid && in_ready;
	assign period_in = (in_item.wrap_period == '0) ? SW'(1) : in_item.wrap_period;
	assign half      = period_q >> 1;

	// datapath
	always_comb begin
		fwd_sum = {1'b0, a_q} + {1'b0, period_q - b_q};
		fwd_sub = fwd_sum - {1'b0, period_q};
		fwd     = (fwd_sum >= {1'b0, period_q}) ? fwd_sub[SW-1:0] : fwd_sum[SW-1:0];
		over    = {{(TIME_BITS-SW){1'b0}}, fwd} > {{(TIME_BITS-IVL_BITS){1'b0}}, ivl_max_q};

		t_sum   = {1'b0, dist_q} + {1'b0, half};
		t_sub   = t_sum - {1'b0, period_q};
		t_nxt   = (t_sum >= {1'b0, period_q}) ? t_sub[SW-1:0] : t_sum[SW-1:0];

		neg_nxt = t_q < half;
		mag_nxt = neg_nxt ? (half - t_q) : (t_q - half);
		mag64   = {{(TIME_BITS-SW){1'b0}}, mag_q};
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:      if (in_xfer) state_nxt = ST_MOD_STAMP;
			ST_MOD_STAMP: if (rem_stat.done) state_nxt = ST_MOD_CLK;
			ST_MOD_CLK:   if (rem_stat.done) state_nxt = ST_REF;
			ST_REF:       state_nxt = ST_SUM;
			ST_SUM:       state_nxt = ST_MAG;
			ST_MAG:       state_nxt = ST_DATE;
			ST_DATE:      state_nxt = ST_DONE;
			ST_DONE:      if (!out_valid_q || out_ready) state_nxt = ST_IDLE;
			default:      state_nxt = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		in_ready         = 1'b0;
		out_load         = 1'b0;
		rem_cmd.start    = 1'b0;
		rem_cmd.dividend = {in_item.orig_stamp, {(TIME_BITS-SW){1'b0}}};
		rem_cmd.nbits    = CNT_BITS'(SW);
		rem_cmd.divisor  = period_in;
		unique case (state_q)
			ST_IDLE: begin
				in_ready      = 1'b1;
				rem_cmd.start = in_xfer;
			end
			ST_MOD_STAMP: begin
				rem_cmd.start    = rem_stat.done;
				rem_cmd.dividend = ref_clock_q;
				rem_cmd.nbits    = CNT_BITS'(TIME_BITS);
				rem_cmd.divisor  = period_q;
			end
			ST_DONE: begin
				out_load = !out_valid_q || out_ready;
			end
			default: begin
			end
		endcase
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			ivl_max_q     <= RESET_INTERVAL;
			delay_max_q   <= RESET_DELAY;
			ref_clock_q   <= RESET_CLOCK;
			prog_offset_q <= '0;
			highest_q     <= RESET_CLOCK;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_nxt;

			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_REF_INTERVAL_MAX: ivl_max_q   <= cfg_data[IVL_BITS-1:0];
					CFG_DATE_DELAY_MAX:   delay_max_q <= cfg_data[DELAY_BITS-1:0];
					default: begin
					end
				endcase
			end

			// reference advance or resync
			if (state_q == ST_REF && is_ref_q) begin
				if (over) begin
					ref_clock_q   <= {{(TIME_BITS-SW){1'b0}}, stamp_q};
					prog_offset_q <= highest_q - {{(TIME_BITS-SW){1'b0}}, stamp_q};
				end else begin
					ref_clock_q <= ref_clock_q + {{(TIME_BITS-SW){1'b0}}, fwd};
				end
			end

			if (out_load && ok_q && date_q > highest_q) begin
				highest_q <= date_q;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			is_ref_q <= in_item.is_reference;
			stamp_q  <= in_item.orig_stamp;
			period_q <= period_in;
		end
		if (state_q == ST_MOD_STAMP && rem_stat.done) a_q <= rem_stat.rem;
		if (state_q == ST_MOD_CLK && rem_stat.done) b_q <= rem_stat.rem;
		if (state_q == ST_REF) begin
			// after a reference update the clock is congruent to the stamp
			dist_q <= is_ref_q ? '0 : fwd;
			disc_q <= is_ref_q && over;
		end
		if (state_q == ST_SUM) begin
			ref_time_q <= ref_clock_q + prog_offset_q;
			t_q        <= t_nxt;
		end
		if (state_q == ST_MAG) begin
			neg_q <= neg_nxt;
			mag_q <= mag_nxt;
			ok_q  <= {{(TIME_BITS-SW){1'b0}}, mag_nxt}
				<= {{(TIME_BITS-DELAY_BITS){1'b0}}, delay_max_q};
		end
		if (state_q == ST_DATE) begin
			date_q <= neg_q ? (ref_time_q - mag64) : (ref_time_q + mag64);
		end
		if (out_load) begin
			out_q.ref_valid         <= is_ref_q;
			out_q.ref_time          <= is_ref_q ? ref_time_q : '0;
			out_q.ref_discontinuity <= disc_q;
			out_q.date_valid        <= ok_q;
			out_q.program_date      <= ok_q ? date_q : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule
